/* rtl/tun_pkg.sv */
// Package for the triangle unit normal pipeline.
// Holds the item types, the datapath widths and the sideband struct.
// Used by rtl/triangle_unit_normal.sv and rtl/triangle_unit_normal_chk.sv.
package tun_pkg;

  localparam int CW  = 24;         // vertex coordinate width
  localparam int EW  = CW + 1;     // edge width
  localparam int PW  = 2 * EW;     // edge product width
  localparam int CB  = PW + 1;     // cross product width
  localparam int MW  = CB - 1;     // cross product magnitude width
  localparam int HW  = MW / 2;     // half of a magnitude for squaring
  localparam int SW  = 2 * MW;     // sum of squares width
  localparam int DW  = SW + 2;     // square root trial width
  localparam int RW  = MW;         // square root width
  localparam int RB  = RW + 2;     // divider remainder width
  localparam int USH = 30;         // fraction bits of a unit component
  localparam int QB  = USH + 1;    // quotient width
  localparam int OW  = 52;         // result component width

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] c_z;
  } vert_t;

  typedef struct packed {
    logic signed [OW-1:0] normal_x;
    logic signed [OW-1:0] normal_y;
    logic signed [OW-1:0] normal_z;
    logic                 degenerate;
  } norm_t;

  typedef struct packed {
    logic [2:0][CB-1:0] c;
    logic [2:0][MW-1:0] m;
    logic               zero;
    logic               nrm;
  } side_t;

endpackage

/* rtl/triangle_unit_normal.sv */
// Triangle face normal: edge cross product, optional scaling to unit length.
// Depends on tun_pkg for item types, widths and the sideband struct.
//
// Channel  Signals                        Payload
// vert     vert_valid, vert_ready, vert   tun_pkg::vert_t, three vertices Q12.12
// norm     norm_valid, norm_ready, norm   tun_pkg::norm_t, normal and degenerate flag
// cfg      cfg_we, cfg_wdata              normalize_enable, reset value 1
//
// One item per cycle enters unless the output stalls. Stages: five arithmetic,
// one per root bit (50), one per quotient bit (31), and the output register.
// The square root and the three dividers set the depth.
// rst clears all valid bits and sets normalize_enable.
// The whole pipeline holds when norm_valid is high and norm_ready is low.
module triangle_unit_normal (
  input  logic           clk,
  input  logic           rst,
  input  logic           vert_valid,
  output logic           vert_ready,
  input  tun_pkg::vert_t vert,
  output logic           norm_valid,
  input  logic           norm_ready,
  output tun_pkg::norm_t norm,
  input  logic           cfg_we,
  input  logic           cfg_wdata
);

  localparam int EW = tun_pkg::EW;
  localparam int PW = tun_pkg::PW;
  localparam int CB = tun_pkg::CB;
  localparam int MW = tun_pkg::MW;
  localparam int HW = tun_pkg::HW;
  localparam int SW = tun_pkg::SW;
  localparam int DW = tun_pkg::DW;
  localparam int RW = tun_pkg::RW;
  localparam int RB = tun_pkg::RB;
  localparam int QB = tun_pkg::QB;
  localparam int OW = tun_pkg::OW;

  logic en;
  logic nrm_en;

  assign en         = !norm_valid || norm_ready;
  assign vert_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      nrm_en <= 1'b1;
    end else if (cfg_we) begin
      nrm_en <= cfg_wdata;
    end
  end

  // Edges.
  logic                 v1;
  logic                 nrm1;
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= vert_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm1  <= nrm_en;
      e1[0] <= EW'(vert.a_x) - EW'(vert.b_x);
      e1[1] <= EW'(vert.a_y) - EW'(vert.b_y);
      e1[2] <= EW'(vert.a_z) - EW'(vert.b_z);
      e2[0] <= EW'(vert.a_x) - EW'(vert.c_x);
      e2[1] <= EW'(vert.a_y) - EW'(vert.c_y);
      e2[2] <= EW'(vert.a_z) - EW'(vert.c_z);
    end
  end

  // Edge products.
  logic                 v2;
  logic                 nrm2;
  logic signed [PW-1:0] p [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm2 <= nrm1;
      p[0] <= e1[1] * e2[2];
      p[1] <= e1[2] * e2[1];
      p[2] <= e1[2] * e2[0];
      p[3] <= e1[0] * e2[2];
      p[4] <= e1[0] * e2[1];
      p[5] <= e1[1] * e2[0];
    end
  end

  // Cross product and magnitudes.
  logic                 v3;
  tun_pkg::side_t       sd3;
  logic signed [CB-1:0] cr [3];
  logic        [CB-1:0] ab [3];

  always_comb begin
    cr[0] = CB'(p[0]) - CB'(p[1]);
    cr[1] = CB'(p[2]) - CB'(p[3]);
    cr[2] = CB'(p[4]) - CB'(p[5]);
    for (int i = 0; i < 3; i++) begin
      ab[i] = cr[i][CB-1] ? CB'(-cr[i]) : CB'(cr[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sd3.c[i] <= cr[i];
        sd3.m[i] <= ab[i][MW-1:0];
      end
      sd3.zero <= (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
      sd3.nrm  <= nrm2;
    end
  end

  // Partial products of the squares.
  logic             v4;
  tun_pkg::side_t   sd4;
  logic [2*HW-1:0]  hh [3];
  logic [2*HW-1:0]  hl [3];
  logic [2*HW-1:0]  ll [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd4 <= sd3;
      for (int i = 0; i < 3; i++) begin
        hh[i] <= sd3.m[i][MW-1:HW] * sd3.m[i][MW-1:HW];
        hl[i] <= sd3.m[i][MW-1:HW] * sd3.m[i][HW-1:0];
        ll[i] <= sd3.m[i][HW-1:0]  * sd3.m[i][HW-1:0];
      end
    end
  end

  // Sum of squares.
  logic           v5;
  tun_pkg::side_t sd5;
  logic [SW-1:0]  s5;
  logic [SW-1:0]  ssum;

  always_comb begin
    ssum = '0;
    for (int i = 0; i < 3; i++) begin
      ssum = ssum + (SW'(hh[i]) << (2 * HW)) + (SW'(hl[i]) << (HW + 1)) + SW'(ll[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd5 <= sd4;
      s5  <= ssum;
    end
  end

  // Square root, one bit per stage, most significant first.
  logic           sq_v   [RW];
  tun_pkg::side_t sq_sd  [RW];
  logic [RW-1:0]  sq_rt  [RW];
  logic [SW-1:0]  sq_rem [RW];

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    localparam int B = RW - 1 - j;
    logic           vi;
    tun_pkg::side_t sdi;
    logic [RW-1:0]  rti;
    logic [SW-1:0]  remi;
    logic [DW-1:0]  dl;
    logic           take;

    if (j == 0) begin : g_first
      always_comb begin
        vi   = v5;
        sdi  = sd5;
        rti  = '0;
        remi = s5;
      end
    end else begin : g_next
      always_comb begin
        vi   = sq_v[j-1];
        sdi  = sq_sd[j-1];
        rti  = sq_rt[j-1];
        remi = sq_rem[j-1];
      end
    end

    always_comb begin
      dl   = (DW'(rti) << (B + 1)) | (DW'(1) << (2 * B));
      take = DW'(remi) >= dl;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j] <= 1'b0;
      end else if (en) begin
        sq_v[j] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_sd[j]  <= sdi;
        sq_rt[j]  <= take ? (rti | (RW'(1) << B)) : rti;
        sq_rem[j] <= take ? (remi - dl[SW-1:0]) : remi;
      end
    end
  end

  // Three restoring dividers, one quotient bit per stage.
  logic               dv_v  [QB];
  tun_pkg::side_t     dv_sd [QB];
  logic [RW-1:0]      dv_d  [QB];
  logic [2:0][RB-1:0] dv_r  [QB];
  logic [2:0][QB-1:0] dv_q  [QB];

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic               vi;
    tun_pkg::side_t     sdi;
    logic [RW-1:0]      di;
    logic [2:0][RB-1:0] ri;
    logic [2:0][QB-1:0] qi;
    logic [2:0][RB-1:0] rs;
    logic [2:0]         take;

    if (k == 0) begin : g_first
      always_comb begin
        vi  = sq_v[RW-1];
        sdi = sq_sd[RW-1];
        di  = sq_rt[RW-1];
        qi  = '0;
        for (int i = 0; i < 3; i++) begin
          ri[i] = RB'(sq_sd[RW-1].m[i]);
        end
      end
    end else begin : g_next
      always_comb begin
        vi  = dv_v[k-1];
        sdi = dv_sd[k-1];
        di  = dv_d[k-1];
        ri  = dv_r[k-1];
        qi  = dv_q[k-1];
      end
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rs[i]   = (k == 0) ? ri[i] : (ri[i] << 1);
        take[i] = rs[i] >= RB'(di);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k] <= 1'b0;
      end else if (en) begin
        dv_v[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_sd[k] <= sdi;
        dv_d[k]  <= di;
        for (int i = 0; i < 3; i++) begin
          dv_r[k][i] <= take[i] ? (rs[i] - RB'(di)) : rs[i];
          dv_q[k][i] <= (qi[i] << 1) | QB'(take[i]);
        end
      end
    end
  end

  // Result selection and output register.
  logic signed [OW-1:0] comp [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_sd[QB-1].zero) begin
        comp[i] = '0;
      end else if (dv_sd[QB-1].nrm) begin
        comp[i] = dv_sd[QB-1].c[i][CB-1] ? -OW'(dv_q[QB-1][i]) : OW'(dv_q[QB-1][i]);
      end else begin
        comp[i] = OW'($signed(dv_sd[QB-1].c[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_valid <= 1'b0;
    end else if (en) begin
      norm_valid <= dv_v[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      norm.normal_x   <= comp[0];
      norm.normal_y   <= comp[1];
      norm.normal_z   <= comp[2];
      norm.degenerate <= dv_sd[QB-1].zero;
    end
  end

endmodule

/* rtl/triangle_unit_normal_chk.sv */
// Port checker for the triangle unit normal pipeline, bound to the top level.
// Depends on tun_pkg for the item types.
module triangle_unit_normal_sva (
  input logic           clk,
  input logic           rst,
  input logic           vert_ready,
  input logic           norm_valid,
  input logic           norm_ready,
  input tun_pkg::norm_t norm
);

  // A reset leaves no item at the output.
  a_reset_empty: assert property (@(posedge clk) rst |=> !norm_valid)
    else $error("result item present after reset");

  // A degenerate item carries zero components.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    norm_valid && norm.degenerate |->
      norm.normal_x == '0 && norm.normal_y == '0 && norm.normal_z == '0)
    else $error("degenerate item with nonzero components");

  // A stalled output stops the input side.
  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    norm_valid && !norm_ready |-> !vert_ready)
    else $error("input accepted while output stalled");

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    norm_valid && !norm_ready |=> norm_valid && $stable(norm))
    else $error("stalled result item changed");

endmodule

bind triangle_unit_normal triangle_unit_normal_sva u_sva (
  .clk        (clk),
  .rst        (rst),
  .vert_ready (vert_ready),
  .norm_valid (norm_valid),
  .norm_ready (norm_ready),
  .norm       (norm)
);
